// ----- src/tsfc_pkg.sv -----
`timescale 1ns / 1ps

package tsfc_pkg;

    // Symbol codes and key cube geometry.
    localparam int CODE_W        = 5;
    localparam int CUBE_ROWS     = 3;
    localparam int CELLS_PER_ROW = 9;
    localparam int CUBE_ROW_W    = CODE_W * CELLS_PER_ROW;
    localparam int DIGITS        = 3;
    localparam int DIGIT_W       = 2;
    localparam int CFG_INDEX_W   = 2;

    // Default group length.
    localparam int DEFAULT_PERIOD = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CUBE_FIRST  = 2'd0,
        CFG_CUBE_MIDDLE = 2'd1,
        CFG_CUBE_LAST   = 2'd2,
        CFG_DECRYPT     = 2'd3
    } cfg_reg_t;

    // The three key tables, row t holds the codes of cells 9t to 9t+8.
    typedef logic [CUBE_ROWS-1:0][CUBE_ROW_W-1:0] cube_t;

    // Base-3 digits of a cell: [0] table, [1] line, [2] column.
    typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_t;

endpackage

// ----- src/tsfc_lookup.sv -----
`timescale 1ns / 1ps

module tsfc_lookup
(
    input  tsfc_pkg::cube_t                    cube,
    input  logic [tsfc_pkg::CODE_W-1:0]        symbol,
    output logic                               found,
    output tsfc_pkg::digits_t                  digits
);
    import tsfc_pkg::*;

    // Search the cube from the last cell down, so the lowest matching cell wins.
    always_comb
    begin
        found  = 1'b0;
        digits = '0;
        for (int t = CUBE_ROWS - 1; t >= 0; t--)
        begin
            for (int l = 2; l >= 0; l--)
            begin
                for (int k = 2; k >= 0; k--)
                begin
                    if (cube[t][(l * 3 + k) * CODE_W +: CODE_W] == symbol)
                    begin
                        found     = 1'b1;
                        digits[0] = DIGIT_W'(t);
                        digits[1] = DIGIT_W'(l);
                        digits[2] = DIGIT_W'(k);
                    end
                end
            end
        end
    end

endmodule

// ----- src/three_square_fractionating_cipher.sv -----
`timescale 1ns / 1ps

// Trifid stream cipher over symbol codes 0 to 26 with a 27-cell key cube.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0, 1
// and 2 load the three key tables (nine 5-bit codes each, cell k at bits 5k),
// index 3 bit 0 selects decryption. cfg_ready is always high; write only
// while no group is in flight.
// Input: in_valid/in_ready carry symbol and end_of_message. A group closes
// after PERIOD symbols or on end_of_message, then yields one result per
// symbol on out_valid/out_ready, the last of the group with group_last set.
// A closed group's digits move from the collection buffer into the drain
// buffer and then the output register. Throughput: one symbol per cycle
// sustained while out_ready is high, since a group is collected in one
// buffer while the previous one drains from another, one result per cycle.
// Stalls: a held result stays on the outputs. Collection goes on; once a
// closed group waits for the drain buffer, in_ready drops until it moves.
// Reset clears the key tables to zero, selects encryption and empties both
// buffers and the output register.
module three_square_fractionating_cipher
#(
    parameter int PERIOD = tsfc_pkg::DEFAULT_PERIOD
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tsfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tsfc_pkg::CUBE_ROW_W-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tsfc_pkg::CODE_W-1:0]           symbol,
    input  logic                                  end_of_message,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tsfc_pkg::CODE_W-1:0]           out_symbol,
    output logic                                  group_last,
    output logic                                  bad_input
);
    import tsfc_pkg::*;

    localparam int CNT_W = $clog2(PERIOD + 1);
    localparam int IDX_W = (PERIOD > 1) ? $clog2(PERIOD) : 1;

    // Configuration registers.
    cube_t       cube_reg;
    logic        decrypt_reg;

    // Collection buffer.
    digits_t           coll_dig_reg [PERIOD];
    logic [CNT_W-1:0]  coll_count_reg;
    logic              coll_bad_reg;
    logic              full_reg;

    // Drain buffer: one digit triple per result, shifted out from entry 0.
    digits_t           emit_lane_reg [PERIOD];
    logic [CNT_W-1:0]  emit_left_reg;
    logic              emit_bad_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    out_symbol_reg;
    logic                 group_last_reg;
    logic                 bad_input_reg;

    logic              found;
    digits_t           in_digits;
    logic              accept;
    logic              advance;
    logic              emit_free;
    logic              transfer;
    logic [CNT_W-1:0]  base_count;
    logic [CNT_W-1:0]  new_count;
    logic              close_group;
    logic [CNT_W-1:0]  n_less;
    logic [IDX_W-1:0]  n_idx;
    logic [CODE_W-1:0] code_next;

    logic [DIGIT_W-1:0] enc_pick [PERIOD][DIGITS][PERIOD];
    logic [DIGIT_W-1:0] dec_pick [PERIOD][DIGITS][PERIOD];
    digits_t            lane_load [PERIOD];

    // Code stored in the cube cell with the given digits.
    function automatic logic [CODE_W-1:0] code_at(input cube_t cube, input digits_t dg);
        logic [CUBE_ROW_W-1:0] row;
        logic [CODE_W-1:0]     code;
        row  = cube[0];
        code = '0;
        unique case (dg[0])
            2'd1:    row = cube[1];
            2'd2:    row = cube[2];
            default: row = cube[0];
        endcase
        for (int l = 0; l < 3; l++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (dg[1] == DIGIT_W'(l) && dg[2] == DIGIT_W'(k))
                begin
                    code = row[(l * 3 + k) * CODE_W +: CODE_W];
                end
            end
        end
        return code;
    endfunction

    tsfc_lookup u_lookup
    (
        .cube   (cube_reg),
        .symbol (symbol),
        .found  (found),
        .digits (in_digits)
    );

    // Handshakes and the hand-over between the two buffers.
    assign cfg_ready  = 1'b1;
    assign advance    = (emit_left_reg != '0) && (!out_valid_reg || out_ready);
    assign emit_free  = (emit_left_reg == '0) || (advance && emit_left_reg == CNT_W'(1));
    assign transfer   = full_reg && emit_free;
    assign in_ready   = !full_reg || transfer;
    assign accept     = in_valid && in_ready;

    assign base_count  = transfer ? '0 : coll_count_reg;
    assign new_count   = base_count + CNT_W'(1);
    assign close_group = (new_count == CNT_W'(PERIOD)) || end_of_message;

    // Group size less one selects the shuffle wiring.
    assign n_less = coll_count_reg - CNT_W'(1);
    assign n_idx  = n_less[IDX_W-1:0];

    // Shuffle wiring for every group size: result j, digit d.
    for (genvar gj = 0; gj < PERIOD; gj++)
    begin : g_res
        for (genvar gd = 0; gd < DIGITS; gd++)
        begin : g_dig
            for (genvar gn = 1; gn <= PERIOD; gn++)
            begin : g_size
                if (gj < gn)
                begin : g_used
                    // Encryption reads the lane layout in consecutive triples.
                    localparam int ENC_POS  = 3 * gj + gd;
                    localparam int ENC_SRC  = ENC_POS % gn;
                    localparam int ENC_KIND = ENC_POS / gn;
                    // Decryption reads the interleaved layout at j, n+j, 2n+j.
                    localparam int DEC_POS  = gd * gn + gj;
                    localparam int DEC_SRC  = DEC_POS / 3;
                    localparam int DEC_KIND = DEC_POS % 3;

                    assign enc_pick[gj][gd][gn-1] = coll_dig_reg[ENC_SRC][ENC_KIND];
                    assign dec_pick[gj][gd][gn-1] = coll_dig_reg[DEC_SRC][DEC_KIND];
                end
                else
                begin : g_unused
                    assign enc_pick[gj][gd][gn-1] = '0;
                    assign dec_pick[gj][gd][gn-1] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < PERIOD; j++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                lane_load[j][d] = decrypt_reg ? dec_pick[j][d][n_idx] : enc_pick[j][d][n_idx];
            end
        end
    end

    assign code_next = code_at(cube_reg, emit_lane_reg[0]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_reg    <= '0;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CUBE_FIRST:  cube_reg[0] <= cfg_data;
                CFG_CUBE_MIDDLE: cube_reg[1] <= cfg_data;
                CFG_CUBE_LAST:   cube_reg[2] <= cfg_data;
                CFG_DECRYPT:     decrypt_reg <= cfg_data[0];
            endcase
        end
    end

    // Collection control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coll_count_reg <= '0;
            coll_bad_reg   <= 1'b0;
            full_reg       <= 1'b0;
        end
        else if (accept)
        begin
            coll_count_reg <= new_count;
            coll_bad_reg   <= (transfer ? 1'b0 : coll_bad_reg) | !found;
            full_reg       <= close_group;
        end
        else if (transfer)
        begin
            coll_count_reg <= '0;
            coll_bad_reg   <= 1'b0;
            full_reg       <= 1'b0;
        end
    end

    // Collection storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coll_dig_reg[base_count[IDX_W-1:0]] <= in_digits;
        end
    end

    // Drain control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_left_reg <= '0;
            emit_bad_reg  <= 1'b0;
        end
        else if (transfer)
        begin
            emit_left_reg <= coll_count_reg;
            emit_bad_reg  <= coll_bad_reg;
        end
        else if (advance)
        begin
            emit_left_reg <= emit_left_reg - CNT_W'(1);
        end
    end

    // Drain storage, shifted by one result at a time.
    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            emit_lane_reg <= lane_load;
        end
        else if (advance)
        begin
            for (int j = 0; j < PERIOD - 1; j++)
            begin
                emit_lane_reg[j] <= emit_lane_reg[j + 1];
            end
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_symbol_reg <= code_next;
            group_last_reg <= (emit_left_reg == CNT_W'(1));
            bad_input_reg  <= emit_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign group_last = group_last_reg;
    assign bad_input  = bad_input_reg;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import tsfc_pkg::*;

    localparam int GROUP_LEN     = DEFAULT_PERIOD;
    localparam int CUBE_CELLS    = CUBE_ROWS * CELLS_PER_ROW;
    localparam int SETTLE_CYCLES = 6;
    localparam int TIMEOUT_NS    = 800000;

    // One enciphered or deciphered output symbol with its flags.
    typedef struct packed {
        logic [CODE_W-1:0] sym;
        logic              last;
        logic              bad;
    } cipher_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CUBE_ROW_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CODE_W-1:0]     symbol;
    logic                  end_of_message;
    logic                  out_valid;
    logic                  out_ready;
    logic [CODE_W-1:0]     out_symbol;
    logic                  group_last;
    logic                  bad_input;

    // Shadow copy of the key cube, the mode and the open group.
    cube_t                 key_cube;
    logic                  decrypt_on;
    int                    group_cells [GROUP_LEN];
    int                    group_fill;
    logic                  group_flag;

    // Cipher outputs that the block still owes, oldest first.
    cipher_out_t           pending_cipher_out[$];

    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    failures;
    int                    symbols_sent;
    int                    outputs_checked;
    int                    groups_closed;
    int                    key_settings;

    three_square_fractionating_cipher
    #(
        .PERIOD(GROUP_LEN)
    )
    i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .symbol(symbol),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_symbol(out_symbol),
        .group_last(group_last),
        .bad_input(bad_input)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Code held in a cube cell of the shadow key.
    function automatic logic [CODE_W-1:0] cell_code(int cell_idx);
        return key_cube[cell_idx / CELLS_PER_ROW][CODE_W * (cell_idx % CELLS_PER_ROW) +: CODE_W];
    endfunction

    // Key cube with every code 0 to 26 once, in order or shuffled.
    function automatic cube_t keyed_cube(bit shuffle);
        int    codes [CUBE_CELLS];
        int    j;
        int    swap;
        cube_t cube;
        for (int k = 0; k < CUBE_CELLS; k++)
        begin
            codes[k] = k;
        end
        if (shuffle)
        begin
            for (int k = CUBE_CELLS - 1; k > 0; k--)
            begin
                j = $urandom_range(k);
                swap = codes[k];
                codes[k] = codes[j];
                codes[j] = swap;
            end
        end
        for (int k = 0; k < CUBE_CELLS; k++)
        begin
            cube[k / CELLS_PER_ROW][CODE_W * (k % CELLS_PER_ROW) +: CODE_W] = CODE_W'(codes[k]);
        end
        return cube;
    endfunction

    // Adds one symbol to the shadow group and, when the group closes,
    // queues the fractionated outputs.
    task automatic fractionate_symbol(logic [CODE_W-1:0] sym, logic eom);
        int          cell_num;
        bit          found;
        int          n;
        int          c;
        int          seq [DIGITS * GROUP_LEN];
        cipher_out_t res;
        cell_num = 0;
        found = 1'b0;
        // The lowest matching cell wins; a missing symbol maps to cell 0.
        for (int k = 0; k < CUBE_CELLS; k++)
        begin
            if (!found && cell_code(k) == sym)
            begin
                found = 1'b1;
                cell_num = k;
            end
        end
        group_cells[group_fill] = cell_num;
        group_fill++;
        if (!found)
        begin
            group_flag = 1'b1;
        end
        if (group_fill == GROUP_LEN || eom)
        begin
            n = group_fill;
            // Spread the table, line and column digits of each cell.
            for (int i = 0; i < n; i++)
            begin
                c = group_cells[i];
                if (decrypt_on)
                begin
                    seq[DIGITS * i]     = c / 9;
                    seq[DIGITS * i + 1] = (c % 9) / 3;
                    seq[DIGITS * i + 2] = c % 3;
                end
                else
                begin
                    seq[i]         = c / 9;
                    seq[n + i]     = (c % 9) / 3;
                    seq[2 * n + i] = c % 3;
                end
            end
            // Read the digits back in the other order.
            for (int i = 0; i < n; i++)
            begin
                if (decrypt_on)
                begin
                    c = seq[i] * 9 + seq[n + i] * 3 + seq[2 * n + i];
                end
                else
                begin
                    c = seq[DIGITS * i] * 9 + seq[DIGITS * i + 1] * 3 + seq[DIGITS * i + 2];
                end
                res.sym  = cell_code(c % CUBE_CELLS);
                res.last = (i == n - 1);
                res.bad  = group_flag;
                pending_cipher_out.push_back(res);
            end
            group_fill = 0;
            group_flag = 1'b0;
            groups_closed++;
        end
    endtask

    // Sends one symbol request, with a random idle gap before it.
    task automatic send_symbol(logic [CODE_W-1:0] sym, logic eom);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        symbol = sym;
        end_of_message = eom;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        fractionate_symbol(sym, eom);
        symbols_sent++;
    endtask

    // Stops sending and waits for every owed output.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cipher_out.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One configuration write request.
    task automatic write_register(cfg_reg_t idx, logic [CUBE_ROW_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_CUBE_FIRST:  key_cube[0] = data;
            CFG_CUBE_MIDDLE: key_cube[1] = data;
            CFG_CUBE_LAST:   key_cube[2] = data;
            CFG_DECRYPT:     decrypt_on = data[0];
            default:         ;
        endcase
    endtask

    // Loads a whole key and mode once the block has gone quiet.
    task automatic program_key(cube_t cube, logic [CUBE_ROW_W-1:0] mode_word);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_CUBE_FIRST, cube[0]);
        write_register(CFG_CUBE_MIDDLE, cube[1]);
        write_register(CFG_CUBE_LAST, cube[2]);
        write_register(CFG_DECRYPT, mode_word);
        @(negedge clk);
        cfg_valid = 1'b0;
        key_settings++;
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each delivered output with the oldest one owed.
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cipher_out.size() == 0)
            begin
                $error("output with nothing owed: out_symbol %0d group_last %0b bad_input %0b",
                       out_symbol, group_last, bad_input);
                failures++;
            end
            else
            begin
                want = pending_cipher_out.pop_front();
                outputs_checked++;
                if (out_symbol !== want.sym)
                begin
                    $error("out_symbol: expected %0d, got %0d", want.sym, out_symbol);
                    failures++;
                end
                if (group_last !== want.last)
                begin
                    $error("group_last: expected %0b, got %0b", want.last, group_last);
                    failures++;
                end
                if (bad_input !== want.bad)
                begin
                    $error("bad_input: expected %0b, got %0b", want.bad, bad_input);
                    failures++;
                end
            end
        end
    end

    // Reset key is all zeros: only symbol 0 is found, 26 and 31 are not.
    task automatic test_reset_cube();
        send_symbol(5'd0, 1'b1);
        send_symbol(5'd26, 1'b1);
        send_symbol(5'd31, 1'b1);
    endtask

    // Ordered key, encryption: a full group, a short group, a single symbol.
    task automatic test_encrypt_groups();
        program_key(keyed_cube(1'b0), '0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd26, 1'b0);
        send_symbol(5'd13, 1'b0);
        send_symbol(5'd5, 1'b0);
        send_symbol(5'd21, 1'b0);
        send_symbol(5'd26, 1'b0);
        send_symbol(5'd1, 1'b0);
        send_symbol(5'd17, 1'b1);
        send_symbol(5'd9, 1'b1);
    endtask

    // Shuffled key, decryption: a full group closed by end of message,
    // then a short one.
    task automatic test_decrypt_groups();
        program_key(keyed_cube(1'b1), 45'd1);
        send_symbol(5'd25, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd14, 1'b0);
        send_symbol(5'd26, 1'b0);
        send_symbol(5'd3, 1'b1);
        send_symbol(5'd11, 1'b0);
        send_symbol(5'd22, 1'b1);
    endtask

    // All-ones table one (code 31 everywhere), all-zero table two,
    // and a mode word with every upper bit set.
    task automatic test_duplicate_and_wide_codes();
        cube_t cube;
        cube[0] = '1;
        cube[1] = '0;
        cube[2] = CUBE_ROW_W'({$urandom, $urandom});
        program_key(cube, '1);
        send_symbol(5'd31, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd7, 1'b0);
        send_symbol(5'd31, 1'b1);
    endtask

    // Random messages under random keys; one pause to drain midway.
    task automatic test_random_traffic(int n_items);
        int  sent;
        int  len;
        bit  noise;
        bit  paused;
        logic [CODE_W-1:0] sym;
        cube_t cube;
        logic [CUBE_ROW_W-1:0] mode_word;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            // Now and then a new key, mostly well formed.
            if ($urandom_range(99) < 35)
            begin
                if ($urandom_range(99) < 75)
                begin
                    cube = keyed_cube(1'b1);
                end
                else
                begin
                    cube[0] = CUBE_ROW_W'({$urandom, $urandom});
                    cube[1] = CUBE_ROW_W'({$urandom, $urandom});
                    cube[2] = CUBE_ROW_W'({$urandom, $urandom});
                end
                mode_word = CUBE_ROW_W'({$urandom, $urandom});
                program_key(cube, mode_word);
            end
            noise = ($urandom_range(99) < 15);
            len = ($urandom_range(99) < 10) ? $urandom_range(13, 18) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if (noise || $urandom_range(99) < 5)
                begin
                    sym = CODE_W'($urandom_range(31));
                end
                else
                begin
                    sym = CODE_W'($urandom_range(26));
                end
                send_symbol(sym, i == len - 1);
                sent++;
                // Let every owed output come back before going on.
                if (!paused && sent >= n_items / 2)
                begin
                    hold_until_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CUBE_FIRST;
        cfg_data = '0;
        in_valid = 1'b0;
        symbol = '0;
        end_of_message = 1'b0;
        out_ready = 1'b0;
        key_cube = '0;
        decrypt_on = 1'b0;
        group_fill = 0;
        group_flag = 1'b0;
        failures = 0;
        symbols_sent = 0;
        outputs_checked = 0;
        groups_closed = 0;
        key_settings = 0;
        send_idle_pct = 30;
        recv_stall_pct = 75;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_cube();
        test_encrypt_groups();
        test_decrypt_groups();
        test_duplicate_and_wide_codes();
        test_random_traffic(65);

        send_idle_pct = 75;
        recv_stall_pct = 30;
        test_random_traffic(65);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(65);

        hold_until_drained();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d symbols in %0d groups under %0d key settings,", symbols_sent,
                 groups_closed, key_settings);
        $display("checked %0d outputs, encryption and decryption, with stalls on both sides.",
                 outputs_checked);
        if (failures == 0)
        begin
            $display("three_square_fractionating_cipher regression: pass");
        end
        else
        begin
            $display("three_square_fractionating_cipher regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("three_square_fractionating_cipher regression: fail");
        $finish;
    end

endmodule
